FILE: sv/bfdh_pkg.sv
// bfdh_pkg: widths, codes, state type and controller/datapath link types
// for the bloom filter double hash unit. No dependencies.

package bfdh_pkg;

  // fixed field widths
  localparam int FILTER_BITS_W = 19;
  localparam int HASH_COUNT_W  = 5;
  localparam int WORD_W        = 64;
  localparam int WORD_INDEX_W  = 12;
  localparam int MODE_W        = 2;
  localparam int BIT_POS_W     = 6;
  localparam int CFG_INDEX_W   = 8;
  localparam int CFG_DATA_W    = 32;

  // bit-serial remainder length, one dividend bit a cycle
  localparam int DIV_STEPS = WORD_W;
  localparam int STEP_W    = 6;

  // parameter defaults
  localparam int DEF_STORE_WORDS = 4096;
  localparam int DEF_MAX_HASHES  = 16;

  // register reset values
  localparam logic [FILTER_BITS_W-1:0] FILTER_BITS_RST = 19'd133390;
  localparam logic [HASH_COUNT_W-1:0]  HASH_COUNT_RST  = 5'd6;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_BITS = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HASH_COUNT  = 8'd1;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD   = 2'd0,
    MODE_TEST  = 2'd1,
    MODE_UNION = 2'd2,
    MODE_ISECT = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REM,
    ST_SETUP,
    ST_HASH_RD,
    ST_HASH_CHK,
    ST_MRG_RD,
    ST_MRG_WR,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic rem_step;
    logic hash_setup;
    logic hash_chk;
    logic mrg_rd;
    logic mrg_wr;
    logic clear_step;
    logic out_load;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic                    is_test;
    logic [HASH_COUNT_W-1:0] k;
    logic                    bit_set;
    logic                    clr_last;
    logic                    out_free;
  } ctrl_status_t;

endpackage

FILE: sv/bfdh_if.sv
// bfdh channel interfaces: input item, result item and register write port
// depends on bfdh_pkg for field widths

interface bfdh_in_if import bfdh_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [MODE_W-1:0]       mode;
  logic [WORD_W-1:0]       hash_low;
  logic [WORD_W-1:0]       hash_high;
  logic [WORD_INDEX_W-1:0] word_index;
  logic [WORD_W-1:0]       word_data;

  modport source (output valid, mode, hash_low, hash_high, word_index, word_data,
                  input ready);
  modport sink (input valid, mode, hash_low, hash_high, word_index, word_data,
                output ready);
endinterface

interface bfdh_out_if import bfdh_pkg::*; ();
  logic valid;
  logic ready;
  logic is_member;
  logic index_error;

  modport source (output valid, is_member, index_error, input ready);
  modport sink (input valid, is_member, index_error, output ready);
endinterface

interface bfdh_cfg_if import bfdh_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/bfdh_rem.sv
// bfdh_rem: bit-serial restoring remainder lane, one dividend bit a cycle while step is high
// depends on bfdh_pkg

module bfdh_rem import bfdh_pkg::*; (
  input  logic                     clk,
  input  logic                     start,
  input  logic                     step,
  input  logic                     bit_in,
  input  logic [FILTER_BITS_W-1:0] modulus,
  output logic [FILTER_BITS_W-1:0] rem
);

  logic [FILTER_BITS_W-1:0] rem_r;
  logic [FILTER_BITS_W-1:0] rem_nxt;
  logic [FILTER_BITS_W:0]   shifted;
  logic [FILTER_BITS_W:0]   mod_ext;

  // shift in next bit, subtract modulus if it fits
  always_comb begin
    shifted = {rem_r, bit_in};
    mod_ext = {1'b0, modulus};
    if (shifted >= mod_ext) begin
      rem_nxt = FILTER_BITS_W'(shifted - mod_ext);
    end else begin
      rem_nxt = FILTER_BITS_W'(shifted);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
    end else if (step) begin
      rem_r <= rem_nxt;
    end
  end

  assign rem = rem_r;

endmodule

FILE: sv/bfdh_dp.sv
// bfdh_dp: datapath with registers, remainder lanes, bit store memory and
// result register; depends on bfdh_pkg and bfdh_rem

module bfdh_dp import bfdh_pkg::*; #(
  parameter int STORE_WORDS = DEF_STORE_WORDS,
  parameter int MAX_HASHES  = DEF_MAX_HASHES
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ctrl_cmd_t               cmd,
  output ctrl_status_t            status,
  input  logic [MODE_W-1:0]       in_mode,
  input  logic [WORD_W-1:0]       in_hash_low,
  input  logic [WORD_W-1:0]       in_hash_high,
  input  logic [WORD_INDEX_W-1:0] in_word_index,
  input  logic [WORD_W-1:0]       in_word_data,
  input  logic                    cfg_valid,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_is_member,
  output logic                    out_index_error
);

  localparam int ADDR_W   = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int CAP_BITS = STORE_WORDS * WORD_W;
  localparam int FW       = FILTER_BITS_W;

  // configuration registers
  logic [FW-1:0]           fb_r;
  logic [HASH_COUNT_W-1:0] hc_r;

  // item registers
  mode_t                   mode_r;
  logic [WORD_W-1:0]       lo_sh_r;
  logic [WORD_W-1:0]       hi_sh_r;
  logic [WORD_W-1:0]       data_r;
  logic [WORD_INDEX_W-1:0] widx_r;
  logic                    err_r;
  logic [FW-1:0]           m_r;
  logic [HASH_COUNT_W-1:0] k_r;
  logic                    member_r;

  // hash walk registers
  logic [FW-1:0]     r_r;
  logic [FW-1:0]     h_r;
  logic [FW-1:0]     t_r;
  logic [WORD_W-1:0] x_r;

  // memory and clearing
  logic [WORD_W-1:0] mem [STORE_WORDS];
  logic [WORD_W-1:0] rdata_r;
  logic [ADDR_W-1:0] clr_addr_r;

  // result register
  logic out_valid_r;
  logic out_member_r;
  logic out_err_r;

  logic [FW-1:0]           m_eff;
  logic [HASH_COUNT_W-1:0] k_eff;
  logic [FW:0]             m_up;
  logic [FW-BIT_POS_W:0]   words_used;
  logic                    err_nxt;
  logic [FW-1:0]           rem_lo;
  logic [FW-1:0]           rem_hi;
  logic [FW-1:0]           rem_one;
  logic [FW:0]             m_ext;
  logic [FW:0]             t_ext;
  logic [FW:0]             t_inc;
  logic [FW-1:0]           t_fix;
  logic [WORD_W:0]         x_sum;
  logic [FW:0]             s0;
  logic [FW:0]             s1;
  logic [FW:0]             s2;
  logic [FW-1:0]           r_adv;
  logic [ADDR_W-1:0]       word_a;
  logic [ADDR_W-1:0]       widx_a;
  logic [BIT_POS_W-1:0]    bit_pos;
  logic                    bit_set;
  logic                    mem_we;
  logic [ADDR_W-1:0]       mem_wa;
  logic [ADDR_W-1:0]       mem_ra;
  logic [WORD_W-1:0]       mem_wd;

  // register writes, index beyond the list is ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_r <= FILTER_BITS_RST;
      hc_r <= HASH_COUNT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FILTER_BITS: fb_r <= cfg_data[FW-1:0];
        CFG_HASH_COUNT:  hc_r <= cfg_data[HASH_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective m and k, merge range check
  always_comb begin
    if (fb_r == '0) begin
      m_eff = FW'(1);
    end else if (int'(fb_r) > CAP_BITS) begin
      m_eff = FW'(CAP_BITS);
    end else begin
      m_eff = fb_r;
    end
    if (int'(hc_r) > MAX_HASHES) begin
      k_eff = HASH_COUNT_W'(MAX_HASHES);
    end else begin
      k_eff = hc_r;
    end
    m_up       = {1'b0, m_eff} + (FW+1)'(WORD_W - 1);
    words_used = m_up[FW:BIT_POS_W];
    err_nxt    = (int'(in_word_index) >= int'(words_used)) ||
                 (int'(in_word_index) >= STORE_WORDS);
  end

  // remainder lanes: base, stride and 2^64-1
  bfdh_rem u_rem_lo (
    .clk     (clk),
    .start   (cmd.load),
    .step    (cmd.rem_step),
    .bit_in  (lo_sh_r[WORD_W-1]),
    .modulus (m_r),
    .rem     (rem_lo)
  );

  bfdh_rem u_rem_hi (
    .clk     (clk),
    .start   (cmd.load),
    .step    (cmd.rem_step),
    .bit_in  (hi_sh_r[WORD_W-1]),
    .modulus (m_r),
    .rem     (rem_hi)
  );

  bfdh_rem u_rem_one (
    .clk     (clk),
    .start   (cmd.load),
    .step    (cmd.rem_step),
    .bit_in  (1'b1),
    .modulus (m_r),
    .rem     (rem_one)
  );

  // 2^64 mod m, and next index: r + h, less 2^64 mod m on a 64-bit wrap
  always_comb begin
    m_ext = {1'b0, m_r};
    t_ext = {1'b0, t_r};
    t_inc = {1'b0, rem_one} + (FW+1)'(1);
    t_fix = (t_inc >= m_ext) ? FW'(t_inc - m_ext) : FW'(t_inc);
    x_sum = {1'b0, x_r} + {1'b0, hi_sh_r};
    s0    = {1'b0, r_r} + {1'b0, h_r};
    s1    = (s0 >= m_ext) ? s0 - m_ext : s0;
    s2    = (s1 >= t_ext) ? s1 - t_ext : s1 + m_ext - t_ext;
    r_adv = x_sum[WORD_W] ? FW'(s2) : FW'(s1);
  end

  // item and hash walk registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r   <= mode_t'(in_mode);
      lo_sh_r  <= in_hash_low;
      hi_sh_r  <= in_hash_high;
      data_r   <= in_word_data;
      widx_r   <= in_word_index;
      err_r    <= err_nxt;
      m_r      <= m_eff;
      k_r      <= k_eff;
      member_r <= 1'b1;
    end else if (cmd.rem_step) begin
      // rotate so the operands are whole again after all steps
      lo_sh_r <= {lo_sh_r[WORD_W-2:0], lo_sh_r[WORD_W-1]};
      hi_sh_r <= {hi_sh_r[WORD_W-2:0], hi_sh_r[WORD_W-1]};
    end
    if (cmd.hash_setup) begin
      r_r <= rem_lo;
      h_r <= rem_hi;
      t_r <= t_fix;
      x_r <= lo_sh_r;
    end else if (cmd.hash_chk) begin
      r_r <= r_adv;
      x_r <= x_sum[WORD_W-1:0];
      if (mode_r == MODE_TEST && !bit_set) begin
        member_r <= 1'b0;
      end
    end
  end

  // addressing
  assign word_a  = ADDR_W'(r_r >> BIT_POS_W);
  assign bit_pos = r_r[BIT_POS_W-1:0];
  assign widx_a  = ADDR_W'(widx_r);
  assign bit_set = rdata_r[bit_pos];

  // memory port selection
  always_comb begin
    mem_ra = cmd.mrg_rd ? widx_a : word_a;
    mem_we = cmd.clear_step || (cmd.hash_chk && mode_r == MODE_ADD) ||
             (cmd.mrg_wr && !err_r);
    if (cmd.clear_step) begin
      mem_wa = clr_addr_r;
    end else if (cmd.mrg_wr) begin
      mem_wa = widx_a;
    end else begin
      mem_wa = word_a;
    end
    if (cmd.clear_step) begin
      mem_wd = '0;
    end else begin
      case (mode_r)
        MODE_ADD:   mem_wd = rdata_r | (WORD_W'(1) << bit_pos);
        MODE_UNION: mem_wd = rdata_r | data_r;
        MODE_ISECT: mem_wd = rdata_r & data_r;
        default:    mem_wd = rdata_r;
      endcase
    end
  end

  // bit store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_r <= mem[mem_ra];
  end

  // clearing pass address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clear_step) begin
      clr_addr_r <= clr_addr_r + ADDR_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_member_r <= (mode_r == MODE_TEST) && member_r;
      out_err_r    <= (mode_r == MODE_UNION || mode_r == MODE_ISECT) && err_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_is_member   = out_member_r;
  assign out_index_error = out_err_r;

  // status to controller
  assign status.is_test  = (mode_r == MODE_TEST);
  assign status.k        = k_r;
  assign status.bit_set  = bit_set;
  assign status.clr_last = (clr_addr_r == ADDR_W'(STORE_WORDS - 1));
  assign status.out_free = !out_valid_r || out_ready;

endmodule

FILE: sv/bfdh_ctrl.sv
// bfdh_ctrl: sequencer for clearing, remainder steps, hash walk and merge
// depends on bfdh_pkg

module bfdh_ctrl import bfdh_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [MODE_W-1:0] in_mode,
  output logic              in_ready,
  input  ctrl_status_t      status,
  output ctrl_cmd_t         cmd
);

  state_t                  state_r;
  state_t                  state_nxt;
  logic [STEP_W-1:0]       step_cnt_r;
  logic [STEP_W-1:0]       step_cnt_nxt;
  logic [HASH_COUNT_W-1:0] hash_cnt_r;
  logic [HASH_COUNT_W-1:0] hash_cnt_nxt;
  logic                    last_hash;
  mode_t                   in_mode_c;

  assign in_mode_c = mode_t'(in_mode);
  assign last_hash = ({1'b0, hash_cnt_r} + (HASH_COUNT_W+1)'(1)) == {1'b0, status.k};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (status.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (in_mode_c inside {MODE_ADD, MODE_TEST}) begin
            state_nxt = ST_REM;
          end else begin
            state_nxt = ST_MRG_RD;
          end
        end
      end
      ST_REM: begin
        if (step_cnt_r == STEP_W'(DIV_STEPS - 1)) state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        state_nxt = (status.k == '0) ? ST_DONE : ST_HASH_RD;
      end
      ST_HASH_RD: state_nxt = ST_HASH_CHK;
      ST_HASH_CHK: begin
        if (last_hash || (status.is_test && !status.bit_set)) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_HASH_RD;
        end
      end
      ST_MRG_RD: state_nxt = ST_MRG_WR;
      ST_MRG_WR: state_nxt = ST_DONE;
      ST_DONE: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // counters
  always_comb begin
    step_cnt_nxt = (state_r == ST_REM) ? step_cnt_r + STEP_W'(1) : '0;
    case (state_r)
      ST_SETUP:    hash_cnt_nxt = '0;
      ST_HASH_CHK: hash_cnt_nxt = hash_cnt_r + HASH_COUNT_W'(1);
      default:     hash_cnt_nxt = hash_cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      step_cnt_r <= '0;
      hash_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      step_cnt_r <= step_cnt_nxt;
      hash_cnt_r <= hash_cnt_nxt;
    end
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_CLEAR:    cmd.clear_step = 1'b1;
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_REM:      cmd.rem_step   = 1'b1;
      ST_SETUP:    cmd.hash_setup = 1'b1;
      ST_HASH_CHK: cmd.hash_chk   = 1'b1;
      ST_MRG_RD:   cmd.mrg_rd     = 1'b1;
      ST_MRG_WR:   cmd.mrg_wr     = 1'b1;
      ST_DONE:     cmd.out_load   = status.out_free;
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != ST_IDLE))
    else $error("accepted item did not start work");

  a_rem_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REM && step_cnt_r == STEP_W'(DIV_STEPS - 1)) |=> (state_r == ST_SETUP))
    else $error("remainder steps did not end on count");

  a_chk_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HASH_CHK) |-> ($past(state_r) == ST_HASH_RD))
    else $error("bit check without a preceding read");

  a_no_hash_done: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.hash_setup && status.k == '0) |=> (state_r == ST_DONE))
    else $error("zero hash count did not finish at once");
`endif

endmodule

FILE: sv/bloom_filter_double_hash_unit.sv
// bloom_filter_double_hash_unit: top level joining controller and datapath
// depends on bfdh_pkg, bfdh_if, bfdh_ctrl and bfdh_dp

// After reset the bit store is cleared one word a cycle, STORE_WORDS words
// (4096 by default), before the first item is taken; register writes are
// taken at any time. An add or test item (k the effective hash count; a
// test stops at the first clear bit) first runs a bit-serial remainder over
// the 64 dividend bits that reduces the base, the stride and 2^64 modulo m
// together, then does one read and one check or write of the bit store per
// hash index. A union or intersect item does one read and one write of the
// addressed word; the write is dropped when the index is out of range. One
// item is worked on at a time; the result waits in an output register, and
// the next item is accepted as soon as it is loaded.

module bloom_filter_double_hash_unit import bfdh_pkg::*; #(
  parameter int STORE_WORDS = DEF_STORE_WORDS,
  parameter int MAX_HASHES  = DEF_MAX_HASHES
) (
  input  logic       clk,
  input  logic       rst_n,
  bfdh_in_if.sink    in_ch,
  bfdh_out_if.source out_ch,
  bfdh_cfg_if.sink   cfg_ch
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;
  logic         in_ready;

  // register writes always taken
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;

  bfdh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_mode  (in_ch.mode),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  bfdh_dp #(
    .STORE_WORDS (STORE_WORDS),
    .MAX_HASHES  (MAX_HASHES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_mode         (in_ch.mode),
    .in_hash_low     (in_ch.hash_low),
    .in_hash_high    (in_ch.hash_high),
    .in_word_index   (in_ch.word_index),
    .in_word_data    (in_ch.word_data),
    .cfg_valid       (cfg_ch.valid),
    .cfg_index       (cfg_ch.index),
    .cfg_data        (cfg_ch.data),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_is_member   (out_ch.is_member),
    .out_index_error (out_ch.index_error)
  );

endmodule
